/* rtl/apm_pkg.sv */
`default_nettype none

package apm_pkg;

	// Table geometry
	localparam int BIN_COUNT    = 33;
	localparam int ROW_COUNT    = 256;
	localparam int TABLE_DEPTH  = BIN_COUNT * ROW_COUNT;
	localparam int ADDR_W       = $clog2(TABLE_DEPTH);
	// context reduction is a mask: ROW_COUNT is a power of two
	localparam int ROW_W        = $clog2(ROW_COUNT);
	// bin index of the lower of two bins (0 .. BIN_COUNT-2)
	localparam int BIN_W        = $clog2(BIN_COUNT - 1);
	// counter over all bins of a row (0 .. BIN_COUNT-1)
	localparam int RAMP_W       = $clog2(BIN_COUNT);

	// Fixed-point formats
	localparam int LOGIT_W = 17;
	localparam int FRAC_W  = 12;
	localparam int RATE_W  = 16;

	typedef logic signed [LOGIT_W-1:0] logit_t;
	typedef logic [FRAC_W-1:0]          frac_t;
	typedef logic [ADDR_W-1:0]          addr_t;

	// Input clamp, 8 - 0.01 in Q4.12
	localparam logit_t CLAMP_LO = -17'sd32727;
	localparam logit_t CLAMP_HI = 17'sd32727;

	// Register map
	localparam logic REG_LEARN_RATE = 1'b0;
	localparam logic [RATE_W-1:0] LEARN_RATE_RESET = 16'd1311;

	// Logistic samples at integer logits 0..17, Q0.16
	localparam int LOGI_N = 18;
	localparam logic [16:0] LOGISTIC_TAB [LOGI_N] = '{
		17'd32768, 17'd47910, 17'd57724, 17'd62428, 17'd64357, 17'd65097,
		17'd65374, 17'd65476, 17'd65514, 17'd65528, 17'd65533, 17'd65535,
		17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536
	};

	// One access to the bin store per cycle
	typedef struct packed {
		logic   we;
		addr_t  addr;
		logit_t wdata;
	} mem_req_t;

	// Reset value of bin b: ramp from -8 to 8 across the row
	function automatic logit_t ramp_value(input logic [RAMP_W-1:0] b);
		logic [RAMP_W+16:0] num;
		logic [RAMP_W+16:0] quo;
		begin
			num = (RAMP_W+17)'({b, 16'd0}) + (RAMP_W+17)'((BIN_COUNT - 1) / 2);
			quo = num / (RAMP_W+17)'(BIN_COUNT - 1);
			return logit_t'(quo[LOGIT_W-1:0] - 17'd32768);
		end
	endfunction

	// Saturate a widened logit to the bin range
	function automatic logit_t sat_logit(input logic signed [LOGIT_W+1:0] v);
		begin
			if (v < -19'sd65536)
				return -17'sd65536;
			else if (v > 19'sd65535)
				return 17'sd65535;
			else
				return v[LOGIT_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/adaptive_probability_map.sv */
`default_nettype none

// Adaptive probability map: refines a Q4.12 logit by interpolating between two
// adjacent bins of a per-context row (256 rows of 33 bins, held in one
// single-port table). A beat carrying update_valid first trains the two bins
// used by the previous beat toward coded_bit. One 32x18 multiplier is shared
// across the multiplying steps under a small sequencer, and every table access
// goes through the one memory port. A beat without learning reads two bins,
// interpolates and presents its result; one with learning first reads and
// writes back the two previous bins. A stalled output holds the beat until it
// frees. After reset the table is swept to its ramp values, one entry per
// cycle, with in_stall high meanwhile; learn_rate can be written during the sweep.
module adaptive_probability_map (
	input  wire                          clk,
	input  wire                          arst_n,
	// input channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          update_valid,
	input  wire                          coded_bit,
	input  wire signed [16:0]            logit_in,
	input  wire [15:0]                   context_req,
	// output channel
	output logic                         out_valid,
	input  wire                          out_stall,
	output apm_pkg::logit_t              logit_out,
	// configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [2:0]                    paddr,
	input  wire [31:0]                   pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import apm_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LG   = 4'd1;
	localparam logic [3:0] S_ERR  = 4'd2;
	localparam logic [3:0] S_E1   = 4'd3;
	localparam logic [3:0] S_P1   = 4'd4;
	localparam logic [3:0] S_P0   = 4'd5;
	localparam logic [3:0] S_W0   = 4'd6;
	localparam logic [3:0] S_RD0  = 4'd7;
	localparam logic [3:0] S_RD1  = 4'd8;
	localparam logic [3:0] S_IP   = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	localparam int SCL_W = LOGIT_W + RAMP_W;

	logic [3:0] state_q;
	logic       bit_q;
	addr_t      cur_addr_q;
	frac_t      cur_frac_q;
	addr_t      last_addr_q;
	frac_t      last_frac_q;
	logit_t     last_logit_q;
	logic [RATE_W-1:0] learn_rate_q;

	logit_t              ta_q;
	logit_t              tb_q;
	logic signed [17:0]  err_q;
	logic signed [31:0]  e0_q;
	logic signed [49:0]  prod_q;
	logic                out_valid_q;
	logit_t              out_q;

	mem_req_t mem_req;
	logit_t   rd_data;
	logic     store_ready;

	logic signed [31:0] mul_a;
	logic signed [17:0] mul_b;

	logic in_acc;
	logic out_free;
	logic cfg_wr;

	// Bin store with its reset sweep
	apm_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data),
		.ready   (store_ready)
	);

	assign in_stall = (state_q != S_IDLE) || !store_ready;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Clamp the incoming logit, map it to a bin and a fraction
	logit_t             clamp_x;
	logic [16:0]        offset;
	logic [SCL_W-1:0]   scaled;
	logic [SCL_W-17:0]  bin_raw;
	logic [BIN_W-1:0]   bin_new;
	addr_t              addr_new;

	always_comb begin
		if (logit_in < CLAMP_LO)
			clamp_x = CLAMP_LO;
		else if (logit_in > CLAMP_HI)
			clamp_x = CLAMP_HI;
		else
			clamp_x = logit_in;
		offset  = 17'(clamp_x) + 17'd32768;
		scaled  = SCL_W'(offset) * SCL_W'(BIN_COUNT - 1);
		bin_raw = scaled[SCL_W-1:16];
		if (bin_raw > (SCL_W-16)'(BIN_COUNT - 2))
			bin_new = BIN_W'(BIN_COUNT - 2);
		else
			bin_new = bin_raw[BIN_W-1:0];
		addr_new = addr_t'(context_req[ROW_W-1:0]) * addr_t'(BIN_COUNT) + addr_t'(bin_new);
	end

	// Logistic of the last output: table segment and slope
	logic signed [17:0] neg_logit;
	logic [16:0]        lg_abs;
	logic [4:0]         lg_k;
	frac_t              lg_f;
	logic [16:0]        lg_lo;
	logic [16:0]        lg_d;
	logic [16:0]        lg_mag;
	logic [16:0]        lg_p;
	logic [29:0]        lg_rnd;
	logic signed [17:0] err_new;

	always_comb begin
		neg_logit = 18'sd0 - 18'(last_logit_q);
		lg_abs    = last_logit_q[16] ? neg_logit[16:0] : last_logit_q[16:0];
		lg_k      = lg_abs[16:12];
		lg_f      = lg_abs[11:0];
		if (lg_k > 5'd16) begin
			lg_k = 5'd16;
			lg_f = 12'd4095;
		end
		lg_lo   = LOGISTIC_TAB[lg_k];
		lg_d    = LOGISTIC_TAB[lg_k + 5'd1] - lg_lo;
		lg_rnd  = prod_q[29:0] + 30'd2048;
		lg_mag  = lg_lo + 17'(lg_rnd[29:12]);
		lg_p    = last_logit_q[16] ? (17'h10000 - lg_mag) : lg_mag;
		err_new = (bit_q ? 18'sd65536 : 18'sd0) - $signed({1'b0, lg_p});
	end

	// Rounded bin step and saturated new bin value
	logic signed [49:0] step_rnd;
	logic signed [17:0] step;
	logit_t             upd_base;
	logit_t             upd_val;

	always_comb begin
		step_rnd = prod_q + 50'sd2147483648;
		step     = step_rnd[49:32];
		upd_base = (state_q == S_P0) ? tb_q : ta_q;
		upd_val  = sat_logit(19'(upd_base) + 19'(step));
	end

	// Interpolated result
	logic signed [49:0] ip_rnd;
	logit_t             ip_val;
	logic signed [17:0] ip_diff;

	always_comb begin
		ip_rnd  = prod_q + 50'sd2048;
		ip_val  = sat_logit(19'(ta_q) + ip_rnd[30:12]);
		ip_diff = 18'(rd_data) - 18'(ta_q);
	end

	// Memory port and shared multiplier operands per step
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = cur_addr_q;
		mem_req.wdata = upd_val;
		mul_a         = '0;
		mul_b         = '0;
		case (state_q)
			S_LG: begin
				mem_req.addr = last_addr_q;
				mul_a        = 32'(lg_d);
				mul_b        = 18'(lg_f);
			end
			S_ERR: begin
				mem_req.addr = last_addr_q + addr_t'(1);
			end
			S_E1: begin
				mul_a = 32'(err_q);
				mul_b = 18'(last_frac_q);
			end
			S_P1: begin
				mul_a = prod_q[31:0];
				mul_b = 18'(learn_rate_q);
			end
			S_P0: begin
				mem_req.we   = 1'b1;
				mem_req.addr = last_addr_q + addr_t'(1);
				mul_a        = e0_q;
				mul_b        = 18'(learn_rate_q);
			end
			S_W0: begin
				mem_req.we   = 1'b1;
				mem_req.addr = last_addr_q;
			end
			S_RD0: begin
				mem_req.addr = cur_addr_q;
			end
			S_RD1: begin
				mem_req.addr = cur_addr_q + addr_t'(1);
			end
			S_IP: begin
				mul_a = 32'(ip_diff);
				mul_b = 18'(cur_frac_q);
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	// Shared multiplier, product held while the result waits for the output
	always_ff @(posedge clk) begin
		if (state_q != S_OUT)
			prod_q <= mul_a * mul_b;
	end

	// Datapath holding registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bit_q      <= coded_bit;
			cur_addr_q <= addr_new;
			cur_frac_q <= scaled[15:4];
		end
		case (state_q)
			S_ERR: begin
				err_q <= err_new;
				ta_q  <= rd_data;
			end
			S_E1: tb_q <= rd_data;
			S_P1: e0_q <= (32'(err_q) <<< FRAC_W) - prod_q[31:0];
			S_RD1: ta_q <= rd_data;
			default: ;
		endcase
	end

	// Sequencer, previous-prediction state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_addr_q  <= '0;
			last_frac_q  <= '0;
			last_logit_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= update_valid ? S_LG : S_RD0;
				end
				S_LG:  state_q <= S_ERR;
				S_ERR: state_q <= S_E1;
				S_E1:  state_q <= S_P1;
				S_P1:  state_q <= S_P0;
				S_P0:  state_q <= S_W0;
				S_W0:  state_q <= S_RD0;
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_IP;
				S_IP:  state_q <= S_OUT;
				S_OUT: begin
					// hold the result until the output register frees up
					if (out_free) begin
						last_addr_q  <= cur_addr_q;
						last_frac_q  <= cur_frac_q;
						last_logit_q <= ip_val;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free)
			out_q <= ip_val;
	end

	assign out_valid = out_valid_q;
	assign logit_out = out_q;

	// Configuration register
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			learn_rate_q <= LEARN_RATE_RESET;
		else if (cfg_wr && paddr[2] == REG_LEARN_RATE)
			learn_rate_q <= pwdata[RATE_W-1:0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LEARN_RATE) ? 32'(learn_rate_q) : 32'd0;

	// No beat is taken while the table sweep runs
	a_sweep_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> in_stall)
		else $error("input accepted during table sweep");

	// An accepted beat closes the input until its result is formed
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input not stalled after acceptance");

	// Finishing a beat loads the output and returns to idle
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("result not presented on completion");

	// Table writes stay inside the table
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (32'(mem_req.addr) < TABLE_DEPTH))
		else $error("table write out of range");

endmodule

`default_nettype wire

/* rtl/apm_store.sv */
`default_nettype none

module apm_store (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire apm_pkg::mem_req_t req,
	output apm_pkg::logit_t        rd_data,
	output logic                   ready
);
	import apm_pkg::*;

	logit_t bin_mem [TABLE_DEPTH];
	logit_t rd_q;

	logic              clearing_q;
	addr_t             clr_addr_q;
	logic [RAMP_W-1:0] clr_bin_q;

	logic   wr_en;
	addr_t  wr_addr;
	logit_t wr_data;

	// Clearing pass owns the write port until it finishes
	always_comb begin
		if (clearing_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = ramp_value(clr_bin_q);
		end else begin
			wr_en   = req.we;
			wr_addr = req.addr;
			wr_data = req.wdata;
		end
	end

	// Single-port table, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			bin_mem[wr_addr] <= wr_data;
		rd_q <= bin_mem[req.addr];
	end

	// Sweep every entry once after reset, bin counter wraps per row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			clr_bin_q  <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + addr_t'(1);
			if (clr_bin_q == RAMP_W'(BIN_COUNT - 1))
				clr_bin_q <= '0;
			else
				clr_bin_q <= clr_bin_q + RAMP_W'(1);
			if (clr_addr_q == addr_t'(TABLE_DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	assign rd_data = rd_q;
	assign ready   = !clearing_q;

endmodule

`default_nettype wire
